/* rtl/msf_pkg.sv */
// Shared constants and types for the morphological switch filter.
package msf_pkg;

    // Window geometry and image limits.
    localparam int WIN         = 5;
    localparam int WIN_N       = WIN * WIN;
    localparam int LINES       = WIN - 1;
    localparam int MAX_WIDTH   = 1024;
    localparam int COUNT_LIMIT = 1024;
    localparam int EFF_W_LIM   = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int SIZE_W     = 11;
    localparam int MASK_W     = 25;
    localparam int ORG_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // Line store geometry: one word holds a column of all buffered rows.
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int LINE_W = LINES * PIX_W;

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SE_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ROW   = 3'd4;

    // Window snapshot, row-major, element r*WIN+c.
    typedef logic [WIN_N-1:0][PIX_W-1:0] msf_win_t;

    // One classified window on its way to the back.
    typedef struct packed {
        msf_win_t           win;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } msf_item_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } msf_qstat_t;

endpackage

/* rtl/morphological_switch_filter_top.sv */
// Top level of the morphological switch filter: configuration and the three parts.
//
// The filter takes one pixel per clock in raster order and gives one result per
// clock for every centre whose 5x5 window lies inside the image. A pixel is
// pushed into a four-entry queue in the cycle after its transfer (line store
// read, then window update), leaves the queue into the first back stage (row
// minimum and maximum) once that stage can load, and then moves on into the
// output register (final switch). The sustained rate of one pixel per cycle is
// set by the line store, a single memory one column wide with one read and one
// write per pixel. When the output stalls the queue fills and the input stalls
// once the queue holds, or is about to receive, four windows. The line store
// and window are not cleared after reset; every result draws only on pixels of
// its own frame. Configuration must be applied only while the filter is idle;
// the block itself does not enforce this.
module morphological_switch_filter_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [msf_pkg::PIX_W-1:0]       s_pixel_in,
    input  logic                            s_frame_begin,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [msf_pkg::PIX_W-1:0]       m_pixel_out,
    output logic [msf_pkg::COORD_W-1:0]     m_out_col,
    output logic [msf_pkg::COORD_W-1:0]     m_out_row,
    output logic                            m_frame_end,
    input  logic                            cfg_we,
    input  logic [msf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SW = msf_pkg::SIZE_W;
    localparam int OW = msf_pkg::ORG_W;

    // Sizes clamp to the supported range; the origin clamps into the window.
    function automatic logic [SW-1:0] clamp_width(input logic [SW-1:0] v);
        logic [SW-1:0] r;
        r = v;
        if (v == '0) begin
            r = SW'(1);
        end else if (v > SW'(msf_pkg::EFF_W_LIM)) begin
            r = SW'(msf_pkg::EFF_W_LIM);
        end
        return r;
    endfunction

    function automatic logic [SW-1:0] clamp_height(input logic [SW-1:0] v);
        logic [SW-1:0] r;
        r = v;
        if (v == '0) begin
            r = SW'(1);
        end else if (v > SW'(msf_pkg::COUNT_LIMIT)) begin
            r = SW'(msf_pkg::COUNT_LIMIT);
        end
        return r;
    endfunction

    function automatic logic [OW-1:0] clamp_origin(input logic [OW-1:0] v);
        return (v > OW'(msf_pkg::WIN - 1)) ? OW'(msf_pkg::WIN - 1) : v;
    endfunction

    localparam logic [SW-1:0] WIDTH_RST  = SW'(640);
    localparam logic [SW-1:0] HEIGHT_RST = SW'(480);
    localparam logic [msf_pkg::MASK_W-1:0] MASK_RST = msf_pkg::MASK_W'(33542145);
    localparam logic [OW-1:0] ORIGIN_RST = OW'(2);

    logic [SW-1:0]              width_reg, height_reg;
    logic [msf_pkg::MASK_W-1:0] mask_reg;
    logic [OW-1:0]              org_col_reg, org_row_reg;

    msf_pkg::msf_item_t  push_item, head_item;
    msf_pkg::msf_qstat_t q_stat;
    logic                q_push, q_pop;

    // Configuration registers, stored in clamped form.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= clamp_width(WIDTH_RST);
            height_reg  <= clamp_height(HEIGHT_RST);
            mask_reg    <= MASK_RST;
            org_col_reg <= clamp_origin(ORIGIN_RST);
            org_row_reg <= clamp_origin(ORIGIN_RST);
        end else if (cfg_we) begin
            unique case (cfg_index)
                msf_pkg::CFG_IMAGE_WIDTH: begin
                    width_reg <= clamp_width(cfg_data[SW-1:0]);
                end
                msf_pkg::CFG_IMAGE_HEIGHT: begin
                    height_reg <= clamp_height(cfg_data[SW-1:0]);
                end
                msf_pkg::CFG_SE_MASK: begin
                    mask_reg <= cfg_data[msf_pkg::MASK_W-1:0];
                end
                msf_pkg::CFG_ORIGIN_COL: begin
                    org_col_reg <= clamp_origin(cfg_data[OW-1:0]);
                end
                msf_pkg::CFG_ORIGIN_ROW: begin
                    org_row_reg <= clamp_origin(cfg_data[OW-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    msf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .s_frame_begin (s_frame_begin),
        .width_eff     (width_reg),
        .height_eff    (height_reg),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    msf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    msf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .se_mask     (mask_reg),
        .org_col     (org_col_reg),
        .org_row     (org_row_reg),
        .head_item   (head_item),
        .head_row    (head_item.row),
        .q_stat      (q_stat),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_out_col   (m_out_col),
        .m_out_row   (m_out_row),
        .m_frame_end (m_frame_end)
    );

endmodule

/* rtl/msf_front.sv */
// Front end: position counters, line store, window register and queue push.
module msf_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [msf_pkg::PIX_W-1:0]       s_pixel_in,
    input  logic                            s_frame_begin,
    input  logic [msf_pkg::SIZE_W-1:0]      width_eff,
    input  logic [msf_pkg::SIZE_W-1:0]      height_eff,
    input  msf_pkg::msf_qstat_t             q_stat,
    output logic                            q_push,
    output msf_pkg::msf_item_t              q_item
);

    localparam int PW = msf_pkg::PIX_W;
    localparam int CW = msf_pkg::COORD_W;
    localparam int SW = msf_pkg::SIZE_W;
    localparam int W  = msf_pkg::WIN;
    localparam int LW = msf_pkg::LINE_W;

    // Line store: one word per column; row k of the word, from k = 0 at the low end, is k+1 lines back.
    logic [LW-1:0] line_mem [msf_pkg::MAX_WIDTH];
    logic [LW-1:0] rd_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;

    // Pixel accepted last cycle, with its column read from the line store.
    logic          a_valid_reg;
    logic [PW-1:0] a_pix_reg;
    logic [CW-1:0] a_col_reg;
    logic [CW-1:0] a_row_reg;
    logic          a_emit_reg;
    logic          a_last_reg;
    logic          a_fwd_reg;
    logic [LW-1:0] a_fwd_data_reg;

    logic [W-1:0][W-1:0][PW-1:0] win_reg, win_next;

    logic          accept;
    logic [CW-1:0] c_base, r_base, c_cur, r_cur;
    logic [SW-1:0] r_step, c_inc, r_inc;
    logic          emit, last;
    logic [LW-1:0] col_word, wdata;
    logic [msf_pkg::QCNT_W:0] pending;

    // Credit check: never accept more than the queue can still hold.
    always_comb begin
        pending = {1'b0, q_stat.count} + {{msf_pkg::QCNT_W{1'b0}}, a_valid_reg & a_emit_reg};
        s_ready = pending < (msf_pkg::QCNT_W + 1)'(msf_pkg::QDEPTH);
    end

    assign accept = s_valid && s_ready;

    // Position of the incoming pixel and of the pixel after it.
    always_comb begin
        c_base = s_frame_begin ? '0 : col_reg;
        r_base = s_frame_begin ? '0 : row_reg;
        if ({1'b0, c_base} >= width_eff) begin
            c_cur  = '0;
            r_step = {1'b0, r_base} + SW'(1);
        end else begin
            c_cur  = c_base;
            r_step = {1'b0, r_base};
        end
        r_cur = (r_step >= height_eff) ? '0 : r_step[CW-1:0];
        c_inc = {1'b0, c_cur} + SW'(1);
        r_inc = {1'b0, r_cur} + SW'(1);
        if (c_inc >= width_eff) begin
            col_next = '0;
            row_next = (r_inc >= height_eff) ? '0 : r_inc[CW-1:0];
        end else begin
            col_next = c_inc[CW-1:0];
            row_next = r_cur;
        end
        emit = (c_cur >= CW'(W - 1)) && (r_cur >= CW'(W - 1));
        last = (c_inc == width_eff) && (r_inc == height_eff);
    end

    // Column from the line store, with the write of the same cycle forwarded.
    always_comb begin
        col_word = a_fwd_reg ? a_fwd_data_reg : rd_reg;
        wdata    = {col_word[LW-PW-1:0], a_pix_reg};
    end

    // Window shifts left by one column; the new column enters on the right.
    always_comb begin
        for (int i = 0; i < W; i++) begin
            for (int j = 0; j < W - 1; j++) begin
                win_next[i][j] = win_reg[i][j+1];
            end
            if (i == W - 1) begin
                win_next[i][W-1] = a_pix_reg;
            end else begin
                win_next[i][W-1] = col_word[(W-2-i)*PW +: PW];
            end
        end
    end

    // Queue entry built from the updated window.
    always_comb begin
        q_push = a_valid_reg && a_emit_reg;
        for (int i = 0; i < W; i++) begin
            for (int j = 0; j < W; j++) begin
                q_item.win[i*W+j] = win_next[i][j];
            end
        end
        q_item.col  = a_col_reg;
        q_item.row  = a_row_reg;
        q_item.last = a_last_reg;
    end

    // Control state: counters and stage valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Stage payload and forwarding of a write to the column just read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pix_reg      <= s_pixel_in;
            a_col_reg      <= c_cur;
            a_row_reg      <= r_cur;
            a_emit_reg     <= emit;
            a_last_reg     <= last;
            a_fwd_reg      <= a_valid_reg && (a_col_reg == c_cur);
            a_fwd_data_reg <= wdata;
        end
        if (a_valid_reg) begin
            win_reg <= win_next;
        end
    end

    // Line store: read at the incoming column, write back the shifted column.
    always_ff @(posedge aclk) begin
        if (a_valid_reg) begin
            line_mem[msf_pkg::ADDR_W'(a_col_reg)] <= wdata;
        end
        if (accept) begin
            rd_reg <= line_mem[msf_pkg::ADDR_W'(c_cur)];
        end
    end

endmodule

/* rtl/msf_queue.sv */
// Short queue of classified windows between the front and the back.
module msf_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  msf_pkg::msf_item_t  push_item,
    input  logic                pop,
    output msf_pkg::msf_item_t  head_item,
    output msf_pkg::msf_qstat_t stat
);

    localparam int PTW = msf_pkg::QPTR_W;
    localparam int CTW = msf_pkg::QCNT_W;

    msf_pkg::msf_item_t entry_reg [msf_pkg::QDEPTH];
    logic [PTW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CTW-1:0] count_reg;

    assign head_item  = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CTW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CTW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/msf_back.sv */
// Back end: masked window minimum and maximum, switch decision, output register.
module msf_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [msf_pkg::MASK_W-1:0]   se_mask,
    input  logic [msf_pkg::ORG_W-1:0]    org_col,
    input  logic [msf_pkg::ORG_W-1:0]    org_row,
    input  msf_pkg::msf_item_t           head_item,
    input  logic [msf_pkg::COORD_W-1:0]  head_row,
    input  msf_pkg::msf_qstat_t          q_stat,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [msf_pkg::PIX_W-1:0]    m_pixel_out,
    output logic [msf_pkg::COORD_W-1:0]  m_out_col,
    output logic [msf_pkg::COORD_W-1:0]  m_out_row,
    output logic                         m_frame_end
);

    localparam int PW  = msf_pkg::PIX_W;
    localparam int CW  = msf_pkg::COORD_W;
    localparam int W   = msf_pkg::WIN;
    localparam int WN  = msf_pkg::WIN_N;
    localparam int IXW = $clog2(WN);

    logic [WN-1:0] mask_win;
    logic          any_sel;

    // First stage: per-row minimum and maximum.
    logic                   s1_valid_reg;
    logic [W-1:0][PW-1:0]   s1_lo_reg, s1_hi_reg;
    logic [PW-1:0]          s1_centre_reg;
    logic [CW-1:0]          s1_col_reg, s1_row_reg;
    logic                   s1_last_reg;

    logic [W-1:0][PW-1:0]   row_lo, row_hi;
    logic [PW-1:0]          centre;
    logic [CW-1:0]          res_col, res_row;

    logic [PW-1:0]          lo, hi, res;
    logic                   out_free, s1_load;

    // Window positions beyond the mask width are not structuring points.
    assign mask_win = WN'(se_mask);
    assign any_sel  = |mask_win;

    // Handshake through the two stages.
    assign out_free = !m_valid || m_ready;
    assign s1_load  = !s1_valid_reg || out_free;
    assign q_pop    = s1_load && !q_stat.empty;

    // Row reductions, centre select and centre coordinates.
    always_comb begin
        for (int i = 0; i < W; i++) begin
            row_lo[i] = '1;
            row_hi[i] = '0;
            for (int j = 0; j < W; j++) begin
                if (mask_win[i*W+j]) begin
                    if (head_item.win[i*W+j] < row_lo[i]) begin
                        row_lo[i] = head_item.win[i*W+j];
                    end
                    if (head_item.win[i*W+j] > row_hi[i]) begin
                        row_hi[i] = head_item.win[i*W+j];
                    end
                end
            end
        end
        centre  = head_item.win[IXW'(int'(org_row) * W + int'(org_col))];
        res_col = head_item.col - CW'(W - 1) + CW'(org_col);
        res_row = head_row - CW'(W - 1) + CW'(org_row);
    end

    // Final reduction over rows and the switch between min, max and centre.
    always_comb begin
        lo = '1;
        hi = '0;
        for (int i = 0; i < W; i++) begin
            if (s1_lo_reg[i] < lo) begin
                lo = s1_lo_reg[i];
            end
            if (s1_hi_reg[i] > hi) begin
                hi = s1_hi_reg[i];
            end
        end
        res = s1_centre_reg;
        if (any_sel) begin
            if (s1_centre_reg < lo) begin
                res = lo;
            end else if (s1_centre_reg > hi) begin
                res = hi;
            end
        end
    end

    // Stage valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            if (s1_load) begin
                s1_valid_reg <= !q_stat.empty;
            end
            if (out_free) begin
                m_valid <= s1_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_lo_reg     <= row_lo;
            s1_hi_reg     <= row_hi;
            s1_centre_reg <= centre;
            s1_col_reg    <= res_col;
            s1_row_reg    <= res_row;
            s1_last_reg   <= head_item.last;
        end
        if (out_free) begin
            m_pixel_out <= res;
            m_out_col   <= s1_col_reg;
            m_out_row   <= s1_row_reg;
            m_frame_end <= s1_last_reg;
        end
    end

endmodule

/* sim/morphological_switch_filter_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the morphological switch filter top level.

module morphological_switch_filter_top_test;

    import msf_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    // Covers the block's registers plus its queue; allow generous slack.
    localparam int DRAIN_CYCLES   = 20;
    // Longest stretch without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 300;
    localparam int REPORT_LIMIT   = 10;

    // One switched pixel as seen on the result channel.
    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } switched_pixel_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // Tracks the filter state, predicts each switched pixel and checks results.
    class switch_filter_checker;
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        logic [MASK_W-1:0] mask_reg;
        logic [ORG_W-1:0]  ocol_reg;
        logic [ORG_W-1:0]  orow_reg;
        logic [PIX_W-1:0]  line_mem [LINES][MAX_WIDTH];
        logic [PIX_W-1:0]  window [WIN_N];
        int unsigned       col_cnt;
        int unsigned       row_cnt;
        switched_pixel_t   switched_q [$];
        int                failures;

        function new();
            width_reg  = 11'd640;
            height_reg = 11'd480;
            mask_reg   = 25'd33542145;
            ocol_reg   = 3'd2;
            orow_reg   = 3'd2;
            foreach (line_mem[i, j]) line_mem[i][j] = '0;
            foreach (window[i]) window[i] = '0;
            col_cnt  = 0;
            row_cnt  = 0;
            failures = 0;
        endfunction

        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg = data[SIZE_W-1:0];
                CFG_SE_MASK:      mask_reg   = data[MASK_W-1:0];
                CFG_ORIGIN_COL:   ocol_reg   = data[ORG_W-1:0];
                CFG_ORIGIN_ROW:   orow_reg   = data[ORG_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the window by one accepted pixel and queue any result it makes.
        function void note_pixel(logic [PIX_W-1:0] pix, logic first);
            int unsigned      w;
            int unsigned      h;
            int unsigned      c;
            int unsigned      r;
            int unsigned      ox;
            int unsigned      oy;
            logic [PIX_W-1:0] column [WIN];
            logic [PIX_W-1:0] centre;
            logic [PIX_W-1:0] lo;
            logic [PIX_W-1:0] hi;
            logic [PIX_W-1:0] res;
            bit               any_point;
            switched_pixel_t  want;

            w = width_reg;
            if (w < 1) w = 1;
            if (w > EFF_W_LIM) w = EFF_W_LIM;
            h = height_reg;
            if (h < 1) h = 1;
            if (h > COUNT_LIMIT) h = COUNT_LIMIT;

            // Position of this pixel, with wrap when the sizes shrank.
            if (first) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
            if (row_cnt >= h) row_cnt = 0;
            c = col_cnt;
            r = row_cnt;

            // New window column: oldest buffered row on top, this pixel at the bottom.
            column[WIN-1] = pix;
            for (int k = 0; k < LINES; k++) column[WIN-2-k] = line_mem[k][c];
            for (int k = LINES - 1; k >= 1; k--) line_mem[k][c] = line_mem[k-1][c];
            line_mem[0][c] = pix;
            for (int i = 0; i < WIN; i++) begin
                for (int j = 0; j < WIN - 1; j++) window[i*WIN+j] = window[i*WIN+j+1];
                window[i*WIN+WIN-1] = column[i];
            end

            // Interior centre: clamp it into the range of the masked neighbors.
            if (c >= WIN - 1 && r >= WIN - 1) begin
                ox = (ocol_reg > WIN - 1) ? WIN - 1 : ocol_reg;
                oy = (orow_reg > WIN - 1) ? WIN - 1 : orow_reg;
                centre    = window[oy*WIN+ox];
                lo        = '1;
                hi        = '0;
                any_point = 1'b0;
                for (int k = 0; k < WIN_N; k++) begin
                    if (k < MASK_W && mask_reg[k]) begin
                        if (window[k] < lo) lo = window[k];
                        if (window[k] > hi) hi = window[k];
                        any_point = 1'b1;
                    end
                end
                res = centre;
                if (any_point) begin
                    if (centre < lo) res = lo;
                    else if (centre > hi) res = hi;
                end
                want.pixel = res;
                want.col   = COORD_W'(c - (WIN - 1) + ox);
                want.row   = COORD_W'(r - (WIN - 1) + oy);
                want.last  = (c + 1 == w) && (r + 1 == h);
                switched_q.push_back(want);
            end

            col_cnt = c + 1;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt = r + 1;
                if (row_cnt >= h) row_cnt = 0;
            end
        endfunction

        // Compare one result transfer with the oldest predicted pixel.
        function void check_result(switched_pixel_t got);
            switched_pixel_t want;

            if (switched_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: unexpected result pixel %0d col %0d row %0d end %0b",
                             $time, got.pixel, got.col, got.row, got.last);
                return;
            end
            want = switched_q.pop_front();
            if (got.pixel !== want.pixel || got.col !== want.col ||
                got.row !== want.row || got.last !== want.last) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"%0t: mismatch expected pixel %0d col %0d row %0d end %0b,",
                              " got pixel %0d col %0d row %0d end %0b"},
                             $time, want.pixel, want.col, want.row, want.last,
                             got.pixel, got.col, got.row, got.last);
            end
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel_in    = '0;
    logic                  s_frame_begin = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [PIX_W-1:0]      m_pixel_out;
    logic [COORD_W-1:0]    m_out_col;
    logic [COORD_W-1:0]    m_out_row;
    logic                  m_frame_end;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    switch_filter_checker board;
    switched_pixel_t      seen_result;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   hold_ticket    = 0;
    int                   hold_seen      = 0;
    int                   hold_left      = 0;
    int                   quiet_cycles   = 0;

    morphological_switch_filter_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .s_frame_begin (s_frame_begin),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_out_col     (m_out_col),
        .m_out_row     (m_out_row),
        .m_frame_end   (m_frame_end),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Observe both channels, feed the checker and watch for a hang.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) board.note_pixel(s_pixel_in, s_frame_begin);
        if (aresetn && m_valid && m_ready) begin
            seen_result = {m_pixel_out, m_out_col, m_out_row, m_frame_end};
            board.check_result(seen_result);
        end
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic void set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 63; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default:       begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel(int unsigned base, int unsigned span);
        int unsigned v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = 255;
            default: v = base + $urandom_range(0, span);
        endcase
        return (v > 255) ? 8'd255 : PIX_W'(v);
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] m;
        m = MASK_W'($urandom);
        case ($urandom_range(0, 4))
            0:       m = '0;
            1:       m = '1;
            2:       m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            3:       m = m & MASK_W'($urandom) & MASK_W'($urandom);
            default: ;
        endcase
        return m;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        board.apply_config(idx, data);
    endtask

    task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                             input logic [MASK_W-1:0] mask,
                             input logic [ORG_W-1:0] ocol, input logic [ORG_W-1:0] orow);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_SE_MASK, CFG_DATA_W'(mask));
        write_reg(CFG_ORIGIN_COL, CFG_DATA_W'(ocol));
        write_reg(CFG_ORIGIN_ROW, CFG_DATA_W'(orow));
        cfg_we <= 1'b0;
    endtask

    // Wait until every predicted pixel has come out and the pipeline has drained.
    task automatic wait_idle();
        @(posedge aclk);
        while (board.switched_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Offer one pixel, with random idle cycles first, and hold it until the transfer.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_in    <= pix;
        s_frame_begin <= first;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_phase(input int w, input int h, input logic [MASK_W-1:0] mask,
                             input int ocol, input int orow, input int npix,
                             input bit begin_first, input int noise_permille,
                             input idle_mode_t mode, input bit hold);
        int unsigned base;
        int unsigned span;
        bit          first;

        wait_idle();
        configure(SIZE_W'(w), SIZE_W'(h), mask, ORG_W'(ocol), ORG_W'(orow));
        set_idle(mode);
        // Narrow pixel bands make the centre leave the neighbor range more often.
        case ($urandom_range(0, 2))
            0:       begin base = 0; span = 255; end
            1:       begin base = $urandom_range(0, 240); span = 15; end
            default: begin base = $urandom_range(0, 252); span = 3; end
        endcase
        if (hold) hold_ticket++;
        for (int i = 0; i < npix; i++) begin
            first = (i == 0 && begin_first) || ($urandom_range(0, 999) < noise_permille);
            send_pixel(random_pixel(base, span), first);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        int w;
        int h;
        int npix;
        int phase;
        int random_items;

        board = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one 5x5 frame whose bright centre is itself a structuring point and so passes unchanged.
        configure(11'd5, 11'd5, 25'd33542145, 3'd2, 3'd2);
        set_idle(IDLE_NONE);
        for (int i = 0; i < WIN_N; i++)
            send_pixel((i == 12) ? 8'd255 : ((i % 2) ? 8'd0 : PIX_W'(100 + i)), i == 0);
        s_valid <= 1'b0;

        // Oversized width saturates to the widest line; the row never wraps early.
        run_phase(2047, 5, random_mask(), 4, 4, 160, 1'b1, 0, IDLE_RECEIVER, 1'b0);
        // Oversized height saturates, origin at the top-left corner, full mask.
        run_phase(5, 2047, '1, 0, 0, 5 * 30, 1'b1, 0, IDLE_NONE, 1'b0);
        // Empty mask passes the centre unchanged.
        run_phase(9, 7, '0, 1, 3, 9 * 7 * 2, 1'b1, 0, IDLE_SENDER, 1'b0);
        // Origin registers above the window saturate to its last row and column.
        run_phase(8, 8, random_mask(), 7, 5, 8 * 8, 1'b1, 0, IDLE_BOTH, 1'b0);
        // Images too small for a window give no result; zero sizes saturate to one.
        run_phase(0, 0, '1, 2, 2, 12, 1'b1, 0, IDLE_NONE, 1'b0);
        run_phase(4, 9, '1, 2, 2, 4 * 9 * 2, 1'b1, 0, IDLE_SENDER, 1'b0);
        run_phase(12, 4, '1, 2, 2, 12 * 4, 1'b1, 0, IDLE_RECEIVER, 1'b0);
        // Stop mid-frame, then shrink both sizes so the counters wrap.
        run_phase(16, 12, random_mask(), 2, 2, 16 * 9 + 7, 1'b1, 0, IDLE_NONE, 1'b0);
        run_phase(6, 11, random_mask(), 2, 2, 200, 1'b0, 0, IDLE_BOTH, 1'b0);
        // Long output hold-off while the input keeps offering pixels.
        run_phase(10, 10, random_mask(), 2, 2, 300, 1'b1, 0, IDLE_NONE, 1'b1);

        // Random frames, mostly well formed, with stray frame starts as noise.
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 20);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            npix = w * h * $urandom_range(1, 3) + $urandom_range(0, w * h);
            run_phase(w, h, random_mask(), $urandom_range(0, 7), $urandom_range(0, 7), npix,
                      $urandom_range(0, 7) != 0, 15, idle_mode_t'(phase % 4), 1'b0);
            random_items += npix;
            phase++;
        end

        wait_idle();
        if (board.switched_q.size() != 0) begin
            $display("%0d predicted results never arrived", board.switched_q.size());
            board.failures += board.switched_q.size();
        end
        if (board.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* morphological_switch_filter_top.f */
rtl/msf_pkg.sv
rtl/msf_front.sv
rtl/msf_queue.sv
rtl/msf_back.sv
rtl/morphological_switch_filter_top.sv
sim/morphological_switch_filter_top_test.sv
